// ----- rtl/lifting_dwt_53_1d_assert.svh -----
// assertion macros for the 5/3 lifting wavelet block
// expects clk and rst in the scope of each use
`ifndef LIFTING_DWT_53_1D_ASSERT_SVH
`define LIFTING_DWT_53_1D_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LDWT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define LDWT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LDWT_ASSERT_IMP(label, ante, cons, msg)

`define LDWT_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/ldwt_pkg.sv -----
// shared constants for the 5/3 lifting wavelet block
// no dependencies; used by the channel interfaces and the top level
package ldwt_pkg;

  localparam int MAX_LEN_DEF     = 64;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SAMPLE_W   = 32;
  localparam int LEVEL_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 1'd1;

endpackage

// ----- rtl/ldwt_if.sv -----
// valid/ready channel interfaces of the 5/3 lifting wavelet block
// depends on ldwt_pkg
interface ldwt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ldwt_pkg::SAMPLE_W-1:0] sample;
  logic                                last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface ldwt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ldwt_pkg::SAMPLE_W-1:0] coefficient;
  logic                                end_of_vector;
  logic                                error;

  modport source (output valid, coefficient, end_of_vector, error, input ready);
  modport sink   (input valid, coefficient, end_of_vector, error, output ready);
endinterface

interface ldwt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ldwt_pkg::CFG_IDX_W-1:0]     index;
  logic [ldwt_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/lifting_dwt_53_1d.sv -----
// one-level 1-d le gall 5/3 lifting wavelet, forward and inverse, in place
// depends on ldwt_pkg, ldwt_if.sv and lifting_dwt_53_1d_assert.svh
//
// Samples stream in on the samples channel at one transfer per cycle until the
// one marked last; that transfer starts the run and samples.ready stays low
// until the final coefficient has been transferred out. Each lifted grid
// position takes a neighbour read, a sum and an update write through a
// single shared adder and a two-read, one-write sample memory, and each pass
// covers about n / 2^(level+1) positions. Coefficients then leave in
// position order, each read from the memory before it is offered, while
// coeffs.ready is high. A failed run (too few samples for the level, or more
// than MAX_LEN) skips the lifting and returns the stored samples with error
// set. Mode and level are taken when the last sample arrives. No clearing
// pass follows reset.
`include "lifting_dwt_53_1d_assert.svh"

module lifting_dwt_53_1d #(
  parameter int MAX_LEN     = ldwt_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = ldwt_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ldwt_in_if.sink    samples,
  ldwt_out_if.source coeffs,
  ldwt_cfg_if.sink   cfg
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = CW + 2;
  localparam int OW = ldwt_pkg::SAMPLE_W;
  localparam int LW = ldwt_pkg::LEVEL_W;

  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,
    S_RD      = 6'b000010,
    S_SUM     = 6'b000100,
    S_WR      = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t state;

  logic          mode;
  logic [LW-1:0] level;

  logic [CW-1:0] count;
  logic          overflow;
  logic          inverse;
  logic          err;
  logic [PW-1:0] inc;
  logic          pass_upd;
  logic          second;
  logic [PW-1:0] t;
  logic [CW-1:0] k;
  logic signed [SB-1:0] acc;

  logic [SB-1:0] mem [MAX_LEN];
  logic [SB-1:0] rd0;
  logic [SB-1:0] rd1;
  logic          rd_en0;
  logic          rd_en1;
  logic [AW-1:0] ra0;
  logic [AW-1:0] ra1;
  logic          we;
  logic [AW-1:0] wa;
  logic [SB-1:0] wd;

  // run set-up at the last sample
  logic          room;
  logic [CW-1:0] n_now;
  logic          ovf_now;
  logic [PW-1:0] inc_calc;
  logic          err_calc;
  logic          in_xfer;
  logic          out_xfer;

  // lifting datapath
  logic          has_left;
  logic          has_right;
  logic          both;
  logic          sub;
  logic [1:0]    sh;
  logic [SB-1:0] shifted;
  logic [SB-1:0] add_a;
  logic [SB-1:0] add_b;
  logic [1:0]    add_c;
  logic [SB-1:0] sum;
  logic [PW-1:0] t_step;
  logic          run_end;

  assign in_xfer  = samples.valid && samples.ready;
  assign out_xfer = coeffs.valid && coeffs.ready;

  assign room     = count < CW'(MAX_LEN);
  assign n_now    = room ? count + CW'(1) : count;
  assign ovf_now  = overflow || !room;
  assign inc_calc = PW'(1) << level;
  assign err_calc = ovf_now || (level >= LW'(CW)) || (PW'(n_now) <= inc_calc);

  assign has_left  = pass_upd ? (t != '0) : 1'b1;
  assign has_right = (t + inc) < PW'(count);
  assign both      = has_left && has_right;
  assign sub       = pass_upd ? inverse : !inverse;
  assign sh        = pass_upd ? (both ? 2'd2 : 2'd1) : (both ? 2'd1 : 2'd0);
  assign shifted   = SB'(acc >>> sh);
  assign t_step    = t + (inc << 1);
  assign run_end   = k == (count - CW'(1));

  // shared adder
  always_comb begin
    add_a = rd0;
    add_b = '0;
    add_c = 2'd0;
    case (state)
      S_SUM: begin
        add_b = both ? rd1 : '0;
        add_c = pass_upd ? (both ? 2'd2 : 2'd1) : 2'd0;
      end
      S_WR: begin
        add_b = sub ? ~shifted : shifted;
        add_c = sub ? 2'd1 : 2'd0;
      end
      default: begin
        add_b = '0;
      end
    endcase
  end

  assign sum = add_a + add_b + SB'(add_c);

  // memory port control
  always_comb begin
    rd_en0 = 1'b0;
    rd_en1 = 1'b0;
    ra0    = AW'(t);
    ra1    = AW'(t + inc);
    we     = 1'b0;
    wa     = AW'(count);
    wd     = samples.sample[SB-1:0];
    case (state)
      S_LOAD: begin
        we = in_xfer && room;
      end
      S_RD: begin
        rd_en0 = 1'b1;
        rd_en1 = 1'b1;
        ra0    = has_left ? AW'(t - inc) : AW'(t + inc);
      end
      S_SUM: begin
        rd_en0 = 1'b1;
      end
      S_WR: begin
        we = 1'b1;
        wa = AW'(t);
        wd = sum;
      end
      S_EMIT_RD: begin
        rd_en0 = 1'b1;
        ra0    = AW'(k);
      end
      default: begin
        rd_en0 = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en0) begin
      rd0 <= mem[ra0];
    end
    if (rd_en1) begin
      rd1 <= mem[ra1];
    end
  end

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      level <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ldwt_pkg::REG_MODE:  mode  <= cfg.data[0];
        ldwt_pkg::REG_LEVEL: level <= cfg.data[LW-1:0];
        default:             mode  <= mode;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      overflow <= 1'b0;
      inverse  <= 1'b0;
      err      <= 1'b0;
      inc      <= '0;
      pass_upd <= 1'b0;
      second   <= 1'b0;
      t        <= '0;
      k        <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            count    <= n_now;
            overflow <= ovf_now;
            if (samples.last) begin
              inverse  <= mode;
              err      <= err_calc;
              inc      <= inc_calc;
              pass_upd <= mode;
              second   <= 1'b0;
              t        <= mode ? '0 : inc_calc;
              k        <= '0;
              state    <= err_calc ? S_EMIT_RD : S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= sum;
          state <= S_WR;
        end
        S_WR: begin
          if (t_step < PW'(count)) begin
            t     <= t_step;
            state <= S_RD;
          end else if (second) begin
            k     <= '0;
            state <= S_EMIT_RD;
          end else begin
            second   <= 1'b1;
            pass_upd <= !pass_upd;
            t        <= pass_upd ? inc : '0;
            state    <= S_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (coeffs.ready) begin
            if (run_end) begin
              count    <= '0;
              overflow <= 1'b0;
              state    <= S_LOAD;
            end else begin
              k     <= k + CW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign samples.ready        = state == S_LOAD;
  assign coeffs.valid         = state == S_EMIT;
  assign coeffs.coefficient   = OW'($signed(rd0));
  assign coeffs.end_of_vector = run_end;
  assign coeffs.error         = err;

  `LDWT_ASSERT_IMP(a_in_out_excl, samples.ready, !coeffs.valid,
                   "input taken while a result is pending")
  `LDWT_ASSERT_NXT(a_run_cleared, out_xfer && coeffs.end_of_vector,
                   count == '0 && !overflow && samples.ready,
                   "run state not cleared after final transfer")
  `LDWT_ASSERT_IMP(a_wr_in_range, state == S_WR, t < PW'(count) && !err,
                   "lifting write outside the loaded vector")
  `LDWT_ASSERT_IMP(a_emit_in_range, coeffs.valid, k < count,
                   "result index beyond the loaded vector")

endmodule

// ----- test/tb_lifting_dwt_53_1d.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the one-level 5/3 lifting wavelet block
// depends on ldwt_pkg, ldwt_if.sv and lifting_dwt_53_1d; holds its own lifting predictor
module tb_lifting_dwt_53_1d;

  localparam int VEC_MAX      = ldwt_pkg::MAX_LEN_DEF;
  localparam int SW           = ldwt_pkg::SAMPLE_W;
  localparam int LVL_W        = ldwt_pkg::LEVEL_W;
  localparam int DIR_ROWS     = 22;
  localparam int RANDOM_ITEMS = 450;
  localparam int TAIL_CYCLES  = 400;

  typedef struct packed {
    logic signed [SW-1:0] coef;
    logic                 eov;
    logic                 err;
  } coeff_t;

  typedef struct packed {
    logic                 mode;
    logic [LVL_W-1:0]     level;
    logic signed [SW-1:0] sample;
    logic                 last;
    logic                 known;
    logic signed [SW-1:0] exp_coef;
    logic                 exp_err;
  } dir_row_t;

  logic clk;
  logic rst;

  ldwt_in_if  samp_ch ();
  ldwt_out_if coef_ch ();
  ldwt_cfg_if cfg_ch ();

  lifting_dwt_53_1d dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samp_ch),
    .coeffs (coef_ch),
    .cfg    (cfg_ch)
  );

  // mode, level, sample, last, typed expectation, coefficient, error
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, 3'd0, 32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff, 1'b1},
    '{1'b0, 3'd0, 32'sh80000000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 3'd0, 32'sh7fffffff, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 3'd0, 32'sh7fffffff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 3'd0, 32'sh80000000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 3'd0, 32'sh7fffffff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 3'd0, 32'sh80000000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b0, 3'd0, 32'sh7fffffff, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{1'b1, 3'd2, 32'sd0,        1'b0, 1'b1, 32'sd0,        1'b1},
    '{1'b1, 3'd2, -32'sd1,       1'b0, 1'b1, -32'sd1,       1'b1},
    '{1'b1, 3'd2, 32'sd1,        1'b0, 1'b1, 32'sd1,        1'b1},
    '{1'b1, 3'd2, 32'sh55555555, 1'b1, 1'b1, 32'sh55555555, 1'b1},
    '{1'b0, 3'd6, 32'sh12345678, 1'b0, 1'b1, 32'sh12345678, 1'b1},
    '{1'b0, 3'd6, -32'sd7,       1'b0, 1'b1, -32'sd7,       1'b1},
    '{1'b0, 3'd6, 32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 1'b1},
    '{1'b1, 3'd7, 32'shaaaaaaaa, 1'b0, 1'b1, 32'shaaaaaaaa, 1'b1},
    '{1'b1, 3'd7, 32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff, 1'b1},
    '{1'b1, 3'd1, 32'sd100,      1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b1, 3'd1, -32'sd3,       1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b1, 3'd1, 32'sh80000000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b1, 3'd1, 32'sh7fffffff, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{1'b1, 3'd1, 32'sd9,        1'b1, 1'b0, 32'sd0, 1'b0}
  };

  // predictor state
  bit              cur_mode;
  bit [LVL_W-1:0]  cur_level;
  int              vec_buf [VEC_MAX];
  int              vec_cnt;
  bit              vec_ovf;
  coeff_t          pending [$];

  int     mismatches;
  int     n_vectors;
  int     n_inverse;
  int     n_flagged;
  int     n_checked;
  int     rand_items;
  bit     no_gaps;
  coeff_t got;
  coeff_t want;
  int     rdy_left;
  bit     rdy_val;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d coefficients outstanding", pending.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void lift_in_place(input int n, input int inc, input bit inv);
    int i;
    int s;
    int u;
    int step;
    step = 2 * inc;
    if (!inv) begin
      for (i = inc; i + inc < n; i += step) begin
        s = vec_buf[i-inc] + vec_buf[i+inc];
        vec_buf[i] = vec_buf[i] - (s >>> 1);
      end
      if (i < n) vec_buf[i] = vec_buf[i] - vec_buf[i-inc];
    end
    s = vec_buf[inc] + 1;
    vec_buf[0] = inv ? vec_buf[0] - (s >>> 1) : vec_buf[0] + (s >>> 1);
    for (i = step; i + inc < n; i += step) begin
      s = vec_buf[i-inc] + vec_buf[i+inc] + 2;
      u = s >>> 2;
      vec_buf[i] = inv ? vec_buf[i] - u : vec_buf[i] + u;
    end
    if (i < n) begin
      s = vec_buf[i-inc] + 1;
      u = s >>> 1;
      vec_buf[i] = inv ? vec_buf[i] - u : vec_buf[i] + u;
    end
    if (inv) begin
      for (i = inc; i + inc < n; i += step) begin
        s = vec_buf[i-inc] + vec_buf[i+inc];
        vec_buf[i] = vec_buf[i] + (s >>> 1);
      end
      if (i < n) vec_buf[i] = vec_buf[i] + vec_buf[i-inc];
    end
  endfunction

  // typed rows carry their own expectations, so only the buffer is kept
  function automatic void take_sample(input int value, input bit is_last, input bit typed);
    int     inc;
    bit     err;
    coeff_t c;
    if (vec_cnt < VEC_MAX) begin
      vec_buf[vec_cnt] = value;
      vec_cnt++;
    end else begin
      vec_ovf = 1'b1;
    end
    if (!is_last) return;
    inc = 1 << cur_level;
    err = vec_ovf || (vec_cnt <= inc);
    n_vectors++;
    if (cur_mode) n_inverse++;
    if (err) n_flagged++;
    if (!typed) begin
      if (!err) lift_in_place(vec_cnt, inc, cur_mode);
      for (int k = 0; k < vec_cnt; k++) begin
        c.coef = vec_buf[k];
        c.eov  = (k == vec_cnt - 1);
        c.err  = err;
        pending.push_back(c);
      end
    end
    vec_cnt = 0;
    vec_ovf = 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int rand_sample();
    int r;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: r = (r < 10) ? 32'sh7fffffff : r;
      1: r = (r < 10) ? 32'sh80000000 : r;
      default: ;
    endcase
    if (r > 99 || r < 0) return r;
    if (r < 40) return $urandom_range(0, 2000) - 1000;
    return $urandom;
  endfunction

  // waits until every coefficient so far has been transferred
  task automatic drain_results();
    samp_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic apply_config(input bit mode, input bit [LVL_W-1:0] level);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ldwt_pkg::REG_MODE;
    cfg_ch.data  <= {2'($urandom), mode};
    do @(posedge clk); while (!cfg_ch.ready);
    cur_mode = mode;
    cfg_ch.index <= ldwt_pkg::REG_LEVEL;
    cfg_ch.data  <= level;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_level = level;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_item(input int value, input bit is_last, input int gap,
                           input bit typed);
    if (gap > 0) begin
      samp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samp_ch.valid  <= 1'b1;
    samp_ch.sample <= value;
    samp_ch.last   <= is_last;
    do @(posedge clk); while (!samp_ch.ready);
    take_sample(value, is_last, typed);
  endtask

  task automatic run_random_vector();
    int lvl;
    int stride;
    int n;
    int r;
    bit inv;
    r = $urandom_range(0, 99);
    if (r < 5) lvl = $urandom_range(6, 7);
    else if (r < 65) lvl = $urandom_range(0, 2);
    else if (r < 88) lvl = $urandom_range(3, 4);
    else lvl = 5;
    stride = 1 << lvl;
    r = $urandom_range(0, 99);
    if (r < 6) n = $urandom_range(VEC_MAX + 1, VEC_MAX + 8);
    else if (r < 16 || stride >= VEC_MAX) n = $urandom_range(1, (stride < VEC_MAX) ? stride : 12);
    else if (r < 26) n = $urandom_range(stride + 1, VEC_MAX);
    else n = $urandom_range(stride + 1, (stride + 20 < VEC_MAX) ? stride + 20 : VEC_MAX);
    inv = 1'($urandom_range(0, 1));
    if (inv != cur_mode || lvl != cur_level) begin
      drain_results();
      apply_config(inv, LVL_W'(lvl));
    end else if ($urandom_range(0, 9) == 0) begin
      drain_results();
    end
    no_gaps = ($urandom_range(0, 99) < 30);
    for (int k = 0; k < n; k++) begin
      send_item(rand_sample(), k == n - 1, pick_gap(), 1'b0);
      rand_items++;
    end
  endtask

  // sink side: random stalls with occasional long stretches of full speed
  initial begin
    coef_ch.ready <= 1'b0;
    rdy_left = 0;
    forever begin
      @(posedge clk);
      if (rdy_left == 0) begin
        case ($urandom_range(0, 99)) inside
          [0:44]:  begin rdy_val = 1'b1; rdy_left = $urandom_range(1, 6); end
          [45:59]: begin rdy_val = 1'b1; rdy_left = $urandom_range(30, 80); end
          [60:91]: begin rdy_val = 1'b0; rdy_left = $urandom_range(1, 3); end
          default: begin rdy_val = 1'b0; rdy_left = $urandom_range(10, 40); end
        endcase
      end
      coef_ch.ready <= rdy_val;
      rdy_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst && coef_ch.valid && coef_ch.ready) begin
      got.coef = coef_ch.coefficient;
      got.eov  = coef_ch.end_of_vector;
      got.err  = coef_ch.error;
      if (pending.size() == 0) begin
        $display("%0t unexpected transfer: coefficient %h eov %b error %b",
                 $time, got.coef, got.eov, got.err);
        mismatches++;
      end else begin
        want = pending.pop_front();
        n_checked++;
        if (got.coef !== want.coef) begin
          $display("%0t coefficient: expected %h, got %h", $time, want.coef, got.coef);
          mismatches++;
        end
        if (got.eov !== want.eov) begin
          $display("%0t end_of_vector: expected %b, got %b", $time, want.eov, got.eov);
          mismatches++;
        end
        if (got.err !== want.err) begin
          $display("%0t error: expected %b, got %b", $time, want.err, got.err);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    bit       vec_start;
    coeff_t   c;
    rst            <= 1'b1;
    samp_ch.valid  <= 1'b0;
    samp_ch.sample <= '0;
    samp_ch.last   <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= ldwt_pkg::REG_MODE;
    cfg_ch.data    <= '0;
    cur_mode   = 1'b0;
    cur_level  = '0;
    vec_cnt    = 0;
    vec_ovf    = 1'b0;
    mismatches = 0;
    n_vectors  = 0;
    n_inverse  = 0;
    n_flagged  = 0;
    n_checked  = 0;
    rand_items = 0;
    no_gaps    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    vec_start = 1'b1;
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_tab[r];
      if (vec_start && (row.mode != cur_mode || row.level != cur_level)) begin
        drain_results();
        apply_config(row.mode, row.level);
      end
      send_item(row.sample, row.last, pick_gap(), row.known);
      if (row.known) begin
        c.coef = row.exp_coef;
        c.eov  = row.last;
        c.err  = row.exp_err;
        pending.push_back(c);
      end
      vec_start = row.last;
    end

    while (rand_items < RANDOM_ITEMS) run_random_vector();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d vectors: %0d inverse, %0d flagged with error", n_vectors, n_inverse,
             n_flagged);
    $display("%0d coefficient transfers checked, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
